// File: hdl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 digest core.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int WordCount = 16;
    localparam int AddrW     = 4;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } md5_in_t;

    typedef struct packed {
        logic [1:0]  word_index;
        logic [31:0] digest_word;
        logic        last_word;
    } md5_out_t;

    typedef struct packed {
        logic             en;
        logic [AddrW-1:0] addr;
        logic [3:0]       be;
        logic [31:0]      data;
    } md5_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FINAL,
        ST_EMIT
    } md5_state_t;

    typedef enum logic [1:0] {
        STG_DATA,
        STG_PAD1,
        STG_LAST
    } md5_stage_t;

    function automatic logic [31:0] md5_k(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [AddrW-1:0] md5_g(input logic [5:0] r);
        logic [7:0] t;
        case (r[5:4])
            2'd0:    t = {2'b00, r};
            2'd1:    t = 8'(5 * r + 1);
            2'd2:    t = 8'(3 * r + 5);
            default: t = 8'(7 * r);
        endcase
        return t[AddrW-1:0];
    endfunction

    function automatic logic [31:0] md5_rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

endpackage

// File: hdl/md5_block_buf.sv
// ----------------------------------------------------------------------------
// md5_block_buf
// Message block store: sixteen 32-bit words, byte write, registered read.
// ----------------------------------------------------------------------------
module md5_block_buf (
    input  logic                 clk,
    input  md5_pkg::md5_wr_t     wr,
    input  logic [md5_pkg::AddrW-1:0] rd_addr,
    output logic [31:0]          rd_data
);
    import md5_pkg::*;

    logic [31:0] mem [WordCount];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (wr.be[i])
                begin
                    mem[wr.addr][8*i +: 8] <= wr.data[8*i +: 8];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/md5_message_digest_core.sv
// ----------------------------------------------------------------------------
// md5_message_digest_core
// MD5 digest over a byte stream with padding and four-word digest output.
//
//   channel | direction | handshake            | payload
//   item    | in        | item_valid/item_stall | md5_in_t  (one byte, end mark)
//   digest  | out       | digest_valid/digest_stall | md5_out_t (one digest word)
//
// Bytes are taken one per cycle while item_stall is low. A full 64-byte block
// runs one round per cycle in a shared round unit fed from the block memory,
// plus read and add. A message end adds a padding sweep and a compression,
// twice when fewer than nine bytes remain in the block, then four output words.
// Reset loads the initial chaining words and clears the counts.
// item_stall is high while a block is padded or compressed or the digest is out.
// ----------------------------------------------------------------------------
module md5_message_digest_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  md5_pkg::md5_in_t  item,
    output logic              digest_valid,
    input  logic              digest_stall,
    output md5_pkg::md5_out_t digest
);
    import md5_pkg::*;

    md5_state_t  state_reg, state_next;
    md5_stage_t  stage_reg;
    logic        fin_reg;
    logic [5:0]  pos_reg;
    logic [63:0] bits_reg;
    logic [6:0]  cnt_reg;
    logic [5:0]  rnd_reg;
    logic [1:0]  idx_reg;
    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;

    md5_wr_t          wr;
    logic [AddrW-1:0] rd_addr;
    logic [31:0]      rd_data;

    logic        take;
    logic        wrap;
    logic [5:0]  pad_start;
    logic        pad_mark;
    logic        pad_len;
    logic [31:0] f_val;
    logic [31:0] t_val;

    md5_block_buf u_buf (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign take = (state_reg == ST_IDLE) && item_valid;
    assign wrap = item.byte_valid && (pos_reg == 6'd63);

    always_comb
    begin
        if (stage_reg == STG_PAD1)
        begin
            pad_start = '0;
            pad_mark  = 1'b0;
            pad_len   = 1'b1;
        end
        else
        begin
            pad_start = pos_reg;
            pad_mark  = 1'b1;
            pad_len   = (pos_reg < LEN_START);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && wrap)
                begin
                    state_next = ST_COMP;
                end
                else if (take && item.end_of_message)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (cnt_reg[3:0] == 4'd15)
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                if (cnt_reg == 7'd64)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (stage_reg == STG_LAST)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                if (!digest_stall && idx_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        wr           = '0;
        rd_addr      = md5_g(cnt_reg[5:0]);
        item_stall   = 1'b1;
        digest_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                wr.en      = take && item.byte_valid;
                wr.addr    = pos_reg[5:2];
                wr.be      = 4'(1 << pos_reg[1:0]);
                wr.data    = {4{item.data_byte}};
            end
            ST_PAD:
            begin
                wr.en   = 1'b1;
                wr.addr = cnt_reg[3:0];
                for (int i = 0; i < 4; i++)
                begin
                    logic [5:0] off;
                    off = {cnt_reg[3:0], 2'(i)};
                    wr.be[i] = (off >= pad_start);
                    if (pad_mark && off == pad_start)
                    begin
                        wr.data[8*i +: 8] = PAD_MARK;
                    end
                    else if (pad_len && off >= LEN_START)
                    begin
                        wr.data[8*i +: 8] = bits_reg[8*off[2:0] +: 8];
                    end
                    else
                    begin
                        wr.data[8*i +: 8] = '0;
                    end
                end
            end
            ST_EMIT:
            begin
                digest_valid = 1'b1;
            end
            default:
            begin
                wr = '0;
            end
        endcase
    end

    assign digest.word_index  = idx_reg;
    assign digest.digest_word = chain_reg[idx_reg];
    assign digest.last_word   = (idx_reg == 2'd3);

    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        t_val = a_reg + f_val + rd_data + md5_k(rnd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            stage_reg    <= STG_DATA;
            fin_reg      <= 1'b0;
            pos_reg      <= '0;
            bits_reg     <= '0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            chain_reg[0] <= IV_A;
            chain_reg[1] <= IV_B;
            chain_reg[2] <= IV_C;
            chain_reg[3] <= IV_D;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg   <= '0;
                    stage_reg <= STG_DATA;
                    fin_reg   <= item.end_of_message;
                    if (take && item.byte_valid)
                    begin
                        pos_reg  <= pos_reg + 6'd1;
                        bits_reg <= bits_reg + 64'd8;
                    end
                end
                ST_PAD:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg[3:0] == 4'd15)
                    begin
                        cnt_reg   <= '0;
                        stage_reg <= pad_len ? STG_LAST : STG_PAD1;
                    end
                end
                ST_COMP:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
                ST_FINAL:
                begin
                    cnt_reg      <= '0;
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                end
                ST_EMIT:
                begin
                    if (!digest_stall)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            chain_reg[0] <= IV_A;
                            chain_reg[1] <= IV_B;
                            chain_reg[2] <= IV_C;
                            chain_reg[3] <= IV_D;
                            bits_reg     <= '0;
                            pos_reg      <= '0;
                            fin_reg      <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg <= cnt_reg[5:0];
        if (state_reg != ST_COMP)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (cnt_reg != 7'd0)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + md5_rotl(t_val, md5_rot(rnd_reg));
        end
    end

endmodule
